>>> rtl/wcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, codes and reset values for the wash cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

	// Configuration register indexes and their reset values.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WASH_HALF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WASH_REPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RINSE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIN      = 3'd4;

	localparam logic [15:0] DEBOUNCE_RST  = 16'd80;
	localparam logic [31:0] WASH_HALF_RST = 32'd5000;
	localparam logic [3:0]  WASH_REPS_RST = 4'd5;
	localparam logic [31:0] RINSE_RST     = 32'd20000;
	localparam logic [31:0] SPIN_RST      = 32'd30000;

	// Button lanes, in the order they are polled.
	localparam int NUM_LANES   = 3;
	localparam int LANE_REDUCE = 0;
	localparam int LANE_FLAT   = 1;
	localparam int LANE_START  = 2;

	// Phase codes as they appear on phase_now.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_WASH   = 3'd1;
	localparam logic [2:0] PH_RINSE  = 3'd2;
	localparam logic [2:0] PH_SPIN   = 3'd3;
	localparam logic [2:0] PH_FINISH = 3'd4;

	// Step codes within a phase.
	localparam logic [1:0] SUB_ENTER = 2'd0;
	localparam logic [1:0] SUB_ONE   = 2'd1;
	localparam logic [1:0] SUB_TWO   = 2'd2;
	localparam logic [1:0] SUB_THREE = 2'd3;

	// LED color codes.
	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_GREEN = 2'd1;
	localparam logic [1:0] LED_BLUE  = 2'd2;

	// Configuration values handed to the sequencer.
	typedef struct packed {
		logic [31:0] wash_half_ms;
		logic [3:0]  wash_repeats;
		logic [31:0] rinse_step_ms;
		logic [31:0] spin_ms;
	} seq_cfg_t;

	// One result transaction.
	typedef struct packed {
		logic       valve_on;
		logic       start_lit;
		logic       flat_lit;
		logic       reduce_lit;
		logic [1:0] wash_color;
		logic [1:0] rinse_color;
		logic       spin_lit;
		logic [2:0] phase_now;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/wcs_db_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_db_lane
// Debounce lane for one active-low button. Flags an accepted press.
// ----------------------------------------------------------------------------
module wcs_db_lane (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        level,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] debounce_ms,
	output logic             press
);

	logic        level_q;
	logic [31:0] last_q;
	logic [31:0] elapsed;
	logic        change;

	// A level change counts only once the debounce window has passed.
	always_comb begin
		elapsed = now_ms - last_q;
		change  = (level != level_q) && (elapsed > {16'd0, debounce_ms});
		press   = change && !level;
	end

	// Accepted level and time of the last accepted change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			last_q  <= '0;
		end else if (step && change) begin
			level_q <= level;
			last_q  <= now_ms;
		end
	end

endmodule
`default_nettype wire

>>> rtl/wcs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_seq
// Merges the lane presses into the flags and advances the cycle one step.
// ----------------------------------------------------------------------------
module wcs_seq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic [31:0]                       now_ms,
	input  wire logic [wcs_pkg::NUM_LANES-1:0]     press,
	input  wire wcs_pkg::seq_cfg_t                 cfg,
	output wcs_pkg::result_t                       res
);

	logic        start_q, flat_q, reduce_q, run_q, valve_q, spin_q;
	logic [2:0]  phase_q;
	logic [1:0]  sub_q, wash_led_q, rinse_led_q;
	logic [3:0]  cnt_q;
	logic [31:0] sst_q;

	logic        n_start, n_flat, n_reduce, n_run, n_valve, n_spin;
	logic [2:0]  n_phase;
	logic [1:0]  n_sub, n_wash_led, n_rinse_led;
	logic [3:0]  n_cnt, cnt_inc;
	logic [31:0] n_sst, elapsed, dur;
	logic        expired;

	// Step timer: one compare against the duration of the current phase.
	always_comb begin
		elapsed = now_ms - sst_q;
		case (phase_q)
			wcs_pkg::PH_WASH:  dur = cfg.wash_half_ms;
			wcs_pkg::PH_RINSE: dur = cfg.rinse_step_ms;
			default:           dur = cfg.spin_ms;
		endcase
		expired = elapsed >= dur;
		cnt_inc = cnt_q + 4'd1;
	end

	// Next state of the whole poll.
	always_comb begin
		n_start     = start_q;
		n_flat      = flat_q;
		n_reduce    = reduce_q;
		n_run       = run_q;
		n_valve     = valve_q;
		n_spin      = spin_q;
		n_phase     = phase_q;
		n_sub       = sub_q;
		n_wash_led  = wash_led_q;
		n_rinse_led = rinse_led_q;
		n_cnt       = cnt_q;
		n_sst       = sst_q;

		if (press[wcs_pkg::LANE_REDUCE]) begin
			n_reduce = ~reduce_q;
		end
		if (press[wcs_pkg::LANE_FLAT]) begin
			n_flat = ~flat_q;
		end

		// Start press arms or cancels; cancelling clears the cycle.
		if (press[wcs_pkg::LANE_START]) begin
			if (!run_q) begin
				n_start = ~start_q;
			end else begin
				n_start = 1'b0;
			end
			if (run_q || start_q) begin
				n_run       = 1'b0;
				n_phase     = wcs_pkg::PH_IDLE;
				n_sub       = wcs_pkg::SUB_ENTER;
				n_cnt       = '0;
				n_wash_led  = wcs_pkg::LED_OFF;
				n_rinse_led = wcs_pkg::LED_OFF;
				n_spin      = 1'b0;
				n_valve     = 1'b0;
			end
		end

		// Arm a new cycle.
		if (n_start && !n_run) begin
			n_run   = 1'b1;
			n_sst   = now_ms;
			n_phase = wcs_pkg::PH_WASH;
			n_sub   = wcs_pkg::SUB_ENTER;
			n_cnt   = '0;
		end

		// Advance the sequencer once.
		if (n_run) begin
			unique case (n_phase)
				wcs_pkg::PH_WASH: begin
					unique case (n_sub)
						wcs_pkg::SUB_ENTER: begin
							n_wash_led = wcs_pkg::LED_GREEN;
							n_sub      = wcs_pkg::SUB_ONE;
							n_sst      = now_ms;
						end
						wcs_pkg::SUB_ONE: begin
							n_wash_led = wcs_pkg::LED_BLUE;
							n_valve    = 1'b1;
							if (expired) begin
								n_sub = wcs_pkg::SUB_TWO;
								n_sst = now_ms;
							end
						end
						wcs_pkg::SUB_TWO: begin
							n_wash_led = wcs_pkg::LED_GREEN;
							n_valve    = 1'b0;
							if (expired) begin
								n_cnt = cnt_inc;
								if (cnt_inc < cfg.wash_repeats) begin
									n_sub = wcs_pkg::SUB_ONE;
								end else begin
									n_wash_led = wcs_pkg::LED_OFF;
									n_phase    = wcs_pkg::PH_RINSE;
									n_sub      = wcs_pkg::SUB_ENTER;
								end
								n_sst = now_ms;
							end
						end
						default: begin
						end
					endcase
				end
				wcs_pkg::PH_RINSE: begin
					unique case (n_sub)
						wcs_pkg::SUB_ENTER: begin
							n_rinse_led = wcs_pkg::LED_GREEN;
							n_valve     = 1'b0;
							n_sst       = now_ms;
							n_sub       = wcs_pkg::SUB_ONE;
						end
						wcs_pkg::SUB_ONE: begin
							if (expired) begin
								n_rinse_led = wcs_pkg::LED_BLUE;
								n_valve     = 1'b1;
								n_sst       = now_ms;
								n_sub       = wcs_pkg::SUB_TWO;
							end
						end
						wcs_pkg::SUB_TWO: begin
							if (expired) begin
								n_rinse_led = wcs_pkg::LED_GREEN;
								n_valve     = 1'b0;
								n_sst       = now_ms;
								n_sub       = wcs_pkg::SUB_THREE;
							end
						end
						default: begin
							// Hold here while flat is set.
							if (!n_flat && expired) begin
								n_rinse_led = wcs_pkg::LED_OFF;
								n_phase     = wcs_pkg::PH_SPIN;
								n_sub       = wcs_pkg::SUB_ENTER;
								n_sst       = now_ms;
							end
						end
					endcase
				end
				wcs_pkg::PH_SPIN: begin
					unique case (n_sub)
						wcs_pkg::SUB_ENTER: begin
							n_spin = 1'b1;
							n_sst  = now_ms;
							n_sub  = wcs_pkg::SUB_ONE;
						end
						wcs_pkg::SUB_ONE: begin
							if (expired) begin
								n_spin  = 1'b0;
								n_phase = wcs_pkg::PH_FINISH;
								n_sub   = wcs_pkg::SUB_ENTER;
								n_sst   = now_ms;
							end
						end
						default: begin
						end
					endcase
				end
				wcs_pkg::PH_FINISH: begin
					n_start     = 1'b0;
					n_run       = 1'b0;
					n_phase     = wcs_pkg::PH_IDLE;
					n_sub       = wcs_pkg::SUB_ENTER;
					n_cnt       = '0;
					n_wash_led  = wcs_pkg::LED_OFF;
					n_rinse_led = wcs_pkg::LED_OFF;
					n_spin      = 1'b0;
					n_valve     = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// The result shows the state after this poll.
	always_comb begin
		res.valve_on    = n_valve;
		res.start_lit   = n_start;
		res.flat_lit    = n_flat;
		res.reduce_lit  = n_reduce;
		res.wash_color  = n_wash_led;
		res.rinse_color = n_rinse_led;
		res.spin_lit    = n_spin;
		res.phase_now   = n_phase;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			flat_q      <= 1'b0;
			reduce_q    <= 1'b0;
			run_q       <= 1'b0;
			valve_q     <= 1'b0;
			spin_q      <= 1'b0;
			phase_q     <= wcs_pkg::PH_IDLE;
			sub_q       <= wcs_pkg::SUB_ENTER;
			wash_led_q  <= wcs_pkg::LED_OFF;
			rinse_led_q <= wcs_pkg::LED_OFF;
			cnt_q       <= '0;
			sst_q       <= '0;
		end else if (step) begin
			start_q     <= n_start;
			flat_q      <= n_flat;
			reduce_q    <= n_reduce;
			run_q       <= n_run;
			valve_q     <= n_valve;
			spin_q      <= n_spin;
			phase_q     <= n_phase;
			sub_q       <= n_sub;
			wash_led_q  <= n_wash_led;
			rinse_led_q <= n_rinse_led;
			cnt_q       <= n_cnt;
			sst_q       <= n_sst;
		end
	end

endmodule
`default_nettype wire

>>> rtl/wash_cycle_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wash_cycle_sequencer
// Debounces three buttons and steps a wash, rinse and spin cycle per poll.
// ----------------------------------------------------------------------------
// Each input transaction is one poll and yields exactly one result
// transaction, registered into the output register, or into the skid entry
// while the output register holds an untaken result. A poll is taken every
// clock: the three debounce lanes compare their elapsed times side by side
// and the sequencer does a single step-timer compare in that same cycle, so the loop
// through the sequencer state closes combinationally. A two-entry output
// buffer lets polls keep coming while a result waits; the input stalls only
// when both entries are full. Configuration writes are always ready and take
// effect at once; writes to unknown indexes are dropped.
module wash_cycle_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write channel.
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data,
	// Poll channel.
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [31:0]                    now_ms,
	input  wire logic                           reduce_button,
	input  wire logic                           flat_button,
	input  wire logic                           start_button,
	// Result channel.
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                valve_on,
	output logic                                start_lit,
	output logic                                flat_lit,
	output logic                                reduce_lit,
	output logic [1:0]                          wash_color,
	output logic [1:0]                          rinse_color,
	output logic                                spin_lit,
	output logic [2:0]                          phase_now
);

	logic [15:0]                    debounce_q;
	wcs_pkg::seq_cfg_t              cfg_q;
	logic                           step;
	logic [wcs_pkg::NUM_LANES-1:0]  levels;
	logic [wcs_pkg::NUM_LANES-1:0]  press;
	wcs_pkg::result_t               res;
	wcs_pkg::result_t               out_q, skid_q;
	logic                           out_valid_q, skid_valid_q, take;

	assign cfg_ready = 1'b1;
	assign step      = in_valid && !in_stall;
	assign in_stall  = skid_valid_q;
	assign take      = out_valid_q && !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q          <= wcs_pkg::DEBOUNCE_RST;
			cfg_q.wash_half_ms  <= wcs_pkg::WASH_HALF_RST;
			cfg_q.wash_repeats  <= wcs_pkg::WASH_REPS_RST;
			cfg_q.rinse_step_ms <= wcs_pkg::RINSE_RST;
			cfg_q.spin_ms       <= wcs_pkg::SPIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wcs_pkg::CFG_DEBOUNCE:  debounce_q          <= cfg_data[15:0];
				wcs_pkg::CFG_WASH_HALF: cfg_q.wash_half_ms  <= cfg_data;
				wcs_pkg::CFG_WASH_REPS: cfg_q.wash_repeats  <= cfg_data[3:0];
				wcs_pkg::CFG_RINSE:     cfg_q.rinse_step_ms <= cfg_data;
				wcs_pkg::CFG_SPIN:      cfg_q.spin_ms       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// One debounce lane per button.
	always_comb begin
		levels[wcs_pkg::LANE_REDUCE] = reduce_button;
		levels[wcs_pkg::LANE_FLAT]   = flat_button;
		levels[wcs_pkg::LANE_START]  = start_button;
	end

	for (genvar g = 0; g < wcs_pkg::NUM_LANES; g++) begin : g_lane
		wcs_db_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (step),
			.level       (levels[g]),
			.now_ms      (now_ms),
			.debounce_ms (debounce_q),
			.press       (press[g])
		);
	end

	// Merge the lanes and step the cycle.
	wcs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.now_ms (now_ms),
		.press  (press),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Two-entry output buffer: output register plus skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (step) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload moves with the buffer control.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (step) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign valve_on    = out_q.valve_on;
	assign start_lit   = out_q.start_lit;
	assign flat_lit    = out_q.flat_lit;
	assign reduce_lit  = out_q.reduce_lit;
	assign wash_color  = out_q.wash_color;
	assign rinse_color = out_q.rinse_color;
	assign spin_lit    = out_q.spin_lit;
	assign phase_now   = out_q.phase_now;

endmodule
`default_nettype wire
